[hw/rtl/akt_pkg.sv]
// Shared constants, codes and types of the access key table.
`default_nettype none

package akt_pkg;

    // Table depth and derived widths.
    localparam int MAX_KEYS   = 10;
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);
    localparam int PROP_W     = (MAX_KEYS > 2) ? $clog2(MAX_KEYS - 1) : 1;

    // Fixed field widths.
    localparam int LOW_W      = 64;
    localparam int HIGH_W     = 16;
    localparam int KEY_W      = LOW_W + HIGH_W;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int HELD_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_MASTER   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DECLINED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_HIGH = 2'd1;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LOW_W-1:0]  key_low;
        logic [HIGH_W-1:0] key_high;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HELD_W-1:0]   entries_held;
    } out_item_t;

    // Commands broadcast from the sequencer to the whole chain.
    typedef struct packed {
        logic load;
        logic init;
        logic prop;
        logic shift;
    } table_ctrl_t;

    // Commands as seen by one cell.
    typedef struct packed {
        logic load;
        logic init;
        logic prop;
        logic shift;
        logic valid;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/akt_cell.sv]
// One table cell: holds a key, compares it and hands it to its lower neighbor.
`default_nettype none

module akt_cell (
    input  wire logic               aclk,
    input  wire akt_pkg::cell_ctrl_t ctrl,
    input  wire akt_pkg::key_t      probe_key,
    input  wire akt_pkg::key_t      next_key,
    input  wire logic               prev_found,
    output akt_pkg::key_t           key_out,
    output logic                    found_out
);
    import akt_pkg::*;

    key_t key_reg;
    logic found_reg;

    // Key storage: written by an add, or takes the upper neighbor's key on compaction.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg <= probe_key;
        end else if (ctrl.shift && found_reg) begin
            key_reg <= next_key;
        end
    end

    // The found flag starts as this cell's own hit and then collects hits from below.
    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            found_reg <= ctrl.valid && (key_reg == probe_key);
        end else if (ctrl.prop) begin
            found_reg <= found_reg | prev_found;
        end
    end

    assign key_out   = key_reg;
    assign found_out = found_reg;

endmodule

`default_nettype wire

[hw/rtl/akt_table.sv]
// Chain of key cells with per-cell valid and load decode.
`default_nettype none

module akt_table (
    input  wire logic                     aclk,
    input  wire akt_pkg::table_ctrl_t     ctrl,
    input  wire logic [akt_pkg::CNT_W-1:0] count,
    input  wire akt_pkg::key_t            probe_key,
    output logic                          any_found
);
    import akt_pkg::*;

    key_t                key_w   [MAX_KEYS];
    logic [MAX_KEYS-1:0] found_w;

    genvar i;
    generate
        for (i = 0; i < MAX_KEYS; i++) begin : g_cell
            cell_ctrl_t cctrl;
            key_t       next_k;
            logic       prev_f;

            // A cell holds a live key when it sits below the fill count.
            always_comb begin
                cctrl.load  = ctrl.load && (count == CNT_W'(i));
                cctrl.init  = ctrl.init;
                cctrl.prop  = ctrl.prop;
                cctrl.shift = ctrl.shift;
                cctrl.valid = (CNT_W'(i) < count);
            end

            if (i == 0) begin : g_first
                assign prev_f = 1'b0;
            end else begin : g_mid
                assign prev_f = found_w[i-1];
            end

            if (i == MAX_KEYS - 1) begin : g_last
                assign next_k = key_w[i];
            end else begin : g_inner
                assign next_k = key_w[i+1];
            end

            akt_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cctrl),
                .probe_key  (probe_key),
                .next_key   (next_k),
                .prev_found (prev_f),
                .key_out    (key_w[i]),
                .found_out  (found_w[i])
            );
        end
    endgenerate

    assign any_found = |found_w;

endmodule

`default_nettype wire

[hw/rtl/access_key_table.sv]
// Top level of the access key table: sequencer, master key registers and result register.
//
// Input channel s_valid/s_ready/s_data carries one word per operation: an op
// (check, add, remove) and an 80-bit key. Result channel m_valid/m_ready/m_data
// returns one word per operation: a status and the number of keys held after it.
// The cfg channel writes the master key halves; cfg_ready is always high and an
// unknown index is ignored.
//
// One operation is in flight at a time. s_ready is high only while the block is
// idle. An add passes through the compare state to the result; a check, or a
// remove that finds nothing, passes through compare and evaluate; a remove that
// finds its key also walks its found flag up the cell chain one cell per cycle
// before the entries above the hit shift down. After the result is taken the
// block is ready again in the next cycle.
//
// Reset empties the table and clears the master key to zero. While m_ready is
// low the result word is held and no new operation is accepted.
`default_nettype none

module access_key_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire akt_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output akt_pkg::out_item_t                   m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [akt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [akt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import akt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMP   = 6'b000010,
        S_EVAL  = 6'b000100,
        S_PROP  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    in_item_t            item_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PROP_W-1:0]   prop_cnt_reg, prop_cnt_next;
    out_item_t           out_reg, out_next;
    logic                out_load;
    logic [LOW_W-1:0]    master_low_reg;
    logic [HIGH_W-1:0]   master_high_reg;
    table_ctrl_t         tctrl;
    key_t                probe_key;
    logic                any_found;
    logic                is_master;
    logic [STATUS_W-1:0] status_next;

    assign probe_key = {item_reg.key_high, item_reg.key_low};
    assign is_master = (item_reg.key_low == master_low_reg)
                    && (item_reg.key_high == master_high_reg);

    // Master key registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_low_reg  <= '0;
            master_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MASTER_LOW:  master_low_reg  <= cfg_data;
                REG_MASTER_HIGH: master_high_reg <= cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        prop_cnt_next = prop_cnt_reg;
        status_next   = ST_DECLINED;
        out_load      = 1'b0;
        tctrl         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                tctrl.init = 1'b1;
                if (item_reg.op == OP_ADD) begin
                    out_load   = 1'b1;
                    state_next = S_OUT;
                    if (count_reg < CNT_W'(MAX_KEYS)) begin
                        tctrl.load  = 1'b1;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_ADDED;
                    end else begin
                        status_next = ST_FULL;
                    end
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                prop_cnt_next = '0;
                if (item_reg.op == OP_REMOVE) begin
                    if (any_found) begin
                        state_next = (MAX_KEYS > 1) ? S_PROP : S_SHIFT;
                    end else begin
                        status_next = ST_NONE;
                        out_load    = 1'b1;
                        state_next  = S_OUT;
                    end
                end else begin
                    // The unused op code behaves as a check.
                    if (is_master) begin
                        status_next = ST_MASTER;
                    end else if (any_found) begin
                        status_next = ST_ACCEPTED;
                    end else begin
                        status_next = ST_DECLINED;
                    end
                    out_load   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_PROP: begin
                tctrl.prop    = 1'b1;
                prop_cnt_next = prop_cnt_reg + 1'b1;
                if (prop_cnt_reg == PROP_W'(MAX_KEYS - 2)) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                tctrl.shift = 1'b1;
                count_next  = count_reg - 1'b1;
                status_next = ST_REMOVED;
                out_load    = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        out_next.status       = status_next;
        out_next.entries_held = HELD_W'(count_next);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            prop_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prop_cnt_reg <= prop_cnt_next;
        end
    end

    // Input word and result word registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    akt_table u_table (
        .aclk      (aclk),
        .ctrl      (tctrl),
        .count     (count_reg),
        .probe_key (probe_key),
        .any_found (any_found)
    );

endmodule

`default_nettype wire

[hw/rtl/akt_checker.sv]
// Port-level checks of the access key table and their binding to the top level.
`default_nettype none

module akt_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire akt_pkg::out_item_t  m_data,
    input wire logic                m_valid,
    input wire logic                m_ready
);
    import akt_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Only one operation in flight: no input is taken while a result waits.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // No result comes in the cycle after an input word is accepted.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early after accept");

    // A successful add leaves at least one key, a status code never goes past the last one.
    a_added_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_ADDED |-> m_data.entries_held != '0)
        else $error("add reported with an empty table");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_NONE)
        else $error("undefined status code");

endmodule

bind access_key_table akt_checker u_akt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

`default_nettype wire
